// File: rtl/core/assert_macros.svh
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, switched off while reset is high
`define MLFC_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked check that also holds through reset
`define MLFC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/core/mlfc_pkg.sv
`default_nettype none
package mlfc_pkg;

   localparam int FRAME_BYTES_DEF = 1024;
   localparam int CSR_DATA_W      = 11;

   // register indexes on the csr port
   localparam logic CSR_DRAW_MODE   = 1'b0;
   localparam logic CSR_BUFFER_SIZE = 1'b1;

   // actions
   localparam logic [1:0] ACT_WRITE = 2'd0;
   localparam logic [1:0] ACT_CLEAR = 2'd1;
   localparam logic [1:0] ACT_TICK  = 2'd2;

   // draw modes
   localparam logic [2:0] MODE_OFF      = 3'd0;
   localparam logic [2:0] MODE_OR       = 3'd1;
   localparam logic [2:0] MODE_ANDNOT   = 3'd2;
   localparam logic [2:0] MODE_OVER     = 3'd3;
   localparam logic [2:0] MODE_OVER_INV = 3'd4;
   localparam logic [2:0] MODE_XOR      = 3'd5;

   localparam logic [2:0]  DRAW_MODE_RST   = MODE_OVER;
   localparam logic [10:0] BUFFER_SIZE_RST = 11'd504;

   // display commands
   localparam logic [7:0] CMD_SET_X     = 8'h80;
   localparam logic [7:0] CMD_SET_Y     = 8'h40;
   localparam logic [7:0] CMD_DISP_NORM = 8'h0C;

   typedef struct packed {
      logic [1:0] action;
      logic [9:0] index;
      logic [7:0] pixel_byte;
      logic [7:0] mask;
   } req_item_type;

   typedef struct packed {
      logic       is_command;
      logic [7:0] out_byte;
      logic       frame_done;
   } rsp_item_type;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_MERGE,
      ST_CLEAR,
      ST_READ_OUT
   } state_type;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_SET_Y,
      PH_DATA
   } phase_type;

   function automatic logic [7:0] merge_byte(input logic [2:0] mode, input logic [7:0] w,
                                             input logic [7:0] d, input logic [7:0] m);
      logic [7:0] r;
      case (mode)
         MODE_OR:       r = w | d;
         MODE_ANDNOT:   r = w & ~d;
         MODE_OVER:     r = (w & ~m) | d;
         MODE_OVER_INV: r = (w & ~m) | (d ^ m);
         MODE_XOR:      r = w ^ d;
         default:       r = w;
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

// File: rtl/core/mlfc_ram.sv
`default_nettype none
module mlfc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

// File: rtl/core/mono_lcd_framebuffer_controller_top.sv
`default_nettype none
// channel   ports                                  timing
// request   start, busy, req_item                  taken when start is high and busy low
// result    rsp_valid, rsp_item                    one-cycle strobe, no back-pressure
// config    csr_wr_en, csr_index, csr_wdata        written on any edge with csr_wr_en high, outside reset
//
// write: one frame store read, then one write back in ST_MERGE with busy high; no busy when ignored
// refresh tick: commands show the cycle after the item, data bytes after a frame store read
//   and the result register; busy is raised on a data tick only
// clear: command the cycle after the item; busy while the bytes in use are swept to zero
// after reset the whole store (FRAME_BYTES bytes) is swept to zero with busy high
// the receiver cannot stall, so nothing ever waits on the result side
module mono_lcd_framebuffer_controller_top #(
   parameter int FRAME_BYTES = mlfc_pkg::FRAME_BYTES_DEF
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   output logic                             busy,
   input  wire mlfc_pkg::req_item_type      req_item,
   output logic                             rsp_valid,
   output mlfc_pkg::rsp_item_type           rsp_item,
   input  wire logic                        csr_wr_en,
   input  wire logic                        csr_index,
   input  wire logic [mlfc_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import mlfc_pkg::*;

   localparam int AW    = $clog2(FRAME_BYTES);
   localparam int CMP_W = (AW + 1 > CSR_DATA_W) ? AW + 1 : CSR_DATA_W;

   state_type        state_ff, state_in;
   phase_type        phase_ff, phase_in;
   logic [AW-1:0]    pos_ff, pos_in;
   logic             pending_ff, pending_in;
   logic [2:0]       draw_mode_ff, draw_mode_in;
   logic [10:0]      buffer_size_ff, buffer_size_in;
   logic [AW-1:0]    addr_ff, addr_in;
   logic [7:0]       pix_ff, pix_in;
   logic [7:0]       mask_ff, mask_in;
   logic             done_ff, done_in;
   logic [CMP_W-1:0] sweep_end_ff, sweep_end_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_item_type     rsp_item_ff, rsp_item_in;

   logic             accept;
   logic [CMP_W-1:0] size_ext, used, limit, idx_ext;
   logic             idx_ok, last_pos, sweep_last;
   logic [AW-1:0]    idx_addr;

   logic             ram_wr_en;
   logic [AW-1:0]    ram_wr_addr, ram_rd_addr;
   logic [7:0]       ram_wr_data, ram_rd_data;

   mlfc_ram #(
      .WIDTH (8),
      .DEPTH (FRAME_BYTES)
   ) u_frame_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign busy   = reset || (state_ff != ST_IDLE);
   assign accept = start && !busy;

   assign size_ext   = CMP_W'(buffer_size_ff);
   assign used       = (size_ext > CMP_W'(FRAME_BYTES)) ? CMP_W'(FRAME_BYTES) : size_ext;
   assign limit      = (used == '0) ? CMP_W'(1) : used;
   assign idx_ext    = CMP_W'(req_item.index);
   assign idx_ok     = idx_ext < used;
   assign idx_addr   = idx_ext[AW-1:0];
   assign last_pos   = (CMP_W'(pos_ff) + CMP_W'(1)) >= limit;
   assign sweep_last = (CMP_W'(addr_ff) + CMP_W'(1)) >= sweep_end_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_INIT, ST_CLEAR: begin
            if (sweep_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               case (req_item.action)
                  ACT_WRITE: state_in = idx_ok ? ST_MERGE : ST_IDLE;
                  ACT_CLEAR: state_in = (used != '0) ? ST_CLEAR : ST_IDLE;
                  ACT_TICK:  state_in = (phase_ff == PH_DATA) ? ST_READ_OUT : ST_IDLE;
                  default:   state_in = ST_IDLE;
               endcase
            end
         end
         ST_MERGE:    state_in = ST_IDLE;
         ST_READ_OUT: state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      phase_in       = phase_ff;
      pos_in         = pos_ff;
      pending_in     = pending_ff;
      draw_mode_in   = draw_mode_ff;
      buffer_size_in = buffer_size_ff;
      addr_in        = addr_ff;
      pix_in         = pix_ff;
      mask_in        = mask_ff;
      done_in        = done_ff;
      sweep_end_in   = sweep_end_ff;
      rsp_valid_in   = 1'b0;
      rsp_item_in    = rsp_item_ff;
      ram_wr_en      = 1'b0;
      ram_wr_addr    = addr_ff;
      ram_wr_data    = '0;
      ram_rd_addr    = pos_ff;

      case (state_ff)
         ST_INIT, ST_CLEAR: begin
            ram_wr_en = 1'b1;
            addr_in   = addr_ff + AW'(1);
         end
         ST_IDLE: begin
            if (accept) begin
               case (req_item.action)
                  ACT_WRITE: begin
                     ram_rd_addr = idx_addr;
                     addr_in     = idx_addr;
                     pix_in      = req_item.pixel_byte;
                     mask_in     = req_item.mask;
                     if (idx_ok) begin
                        pending_in = 1'b1;
                     end
                  end
                  ACT_CLEAR: begin
                     rsp_valid_in = 1'b1;
                     rsp_item_in  = '{is_command: 1'b1, out_byte: CMD_DISP_NORM,
                                      frame_done: 1'b0};
                     addr_in      = '0;
                     sweep_end_in = used;
                  end
                  ACT_TICK: begin
                     case (phase_ff)
                        PH_SET_Y: begin
                           rsp_valid_in = 1'b1;
                           rsp_item_in  = '{is_command: 1'b1, out_byte: CMD_SET_Y,
                                            frame_done: 1'b0};
                           phase_in     = PH_DATA;
                           pos_in       = '0;
                        end
                        PH_DATA: begin
                           ram_rd_addr = pos_ff;
                           done_in     = last_pos;
                           if (last_pos) begin
                              phase_in = PH_IDLE;
                              pos_in   = '0;
                           end else begin
                              pos_in = pos_ff + AW'(1);
                           end
                        end
                        default: begin
                           phase_in = PH_IDLE;
                           if (pending_ff) begin
                              pending_in   = 1'b0;
                              phase_in     = PH_SET_Y;
                              rsp_valid_in = 1'b1;
                              rsp_item_in  = '{is_command: 1'b1, out_byte: CMD_SET_X,
                                               frame_done: 1'b0};
                           end
                        end
                     endcase
                  end
                  default: ;
               endcase
            end
         end
         ST_MERGE: begin
            ram_wr_en   = 1'b1;
            ram_wr_data = merge_byte(draw_mode_ff, ram_rd_data, pix_ff, mask_ff);
         end
         ST_READ_OUT: begin
            rsp_valid_in = 1'b1;
            rsp_item_in  = '{is_command: 1'b0, out_byte: ram_rd_data, frame_done: done_ff};
         end
         default: ;
      endcase

      if (csr_wr_en) begin
         case (csr_index)
            CSR_DRAW_MODE:   draw_mode_in   = csr_wdata[2:0];
            CSR_BUFFER_SIZE: buffer_size_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_INIT;
         phase_ff       <= PH_IDLE;
         pos_ff         <= '0;
         pending_ff     <= 1'b0;
         draw_mode_ff   <= DRAW_MODE_RST;
         buffer_size_ff <= BUFFER_SIZE_RST;
         addr_ff        <= '0;
         sweep_end_ff   <= CMP_W'(FRAME_BYTES);
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         phase_ff       <= phase_in;
         pos_ff         <= pos_in;
         pending_ff     <= pending_in;
         draw_mode_ff   <= draw_mode_in;
         buffer_size_ff <= buffer_size_in;
         addr_ff        <= addr_in;
         sweep_end_ff   <= sweep_end_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pix_ff      <= pix_in;
      mask_ff     <= mask_in;
      done_ff     <= done_in;
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule
`default_nettype wire

// File: rtl/core/mlfc_checker.sv
`default_nettype none
`include "assert_macros.svh"
module mlfc_checker (
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   start,
   input wire logic                   busy,
   input wire mlfc_pkg::req_item_type req_item,
   input wire logic                   rsp_valid,
   input wire mlfc_pkg::rsp_item_type rsp_item
);
   import mlfc_pkg::*;

   logic acc_write, acc_clear;

   assign acc_write = start && !busy && (req_item.action == ACT_WRITE);
   assign acc_clear = start && !busy && (req_item.action == ACT_CLEAR);

   // the zero sweep holds the request side off right after reset
   `MLFC_ASSERT_ALWAYS(a_busy_after_reset, clock, reset |=> busy, "no busy after reset")

   `MLFC_ASSERT(a_write_no_result, clock, reset, acc_write |=> !rsp_valid,
                "write item gave a result")

   // a result follows either an accepted item or a busy cycle
   `MLFC_ASSERT(a_rsp_has_cause, clock, reset, rsp_valid |-> $past(start || busy),
                "result with no item or busy cycle before it")

   `MLFC_ASSERT(a_clear_cmd, clock, reset,
                acc_clear |=> rsp_valid && rsp_item.is_command &&
                (rsp_item.out_byte == CMD_DISP_NORM) && !rsp_item.frame_done,
                "clear item did not send display normal")

   `MLFC_ASSERT(a_done_on_data, clock, reset,
                (rsp_valid && rsp_item.frame_done) |-> !rsp_item.is_command,
                "frame done on a command byte")

endmodule

bind mono_lcd_framebuffer_controller_top mlfc_checker u_mlfc_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .req_item  (req_item),
   .rsp_valid (rsp_valid),
   .rsp_item  (rsp_item)
);
`default_nettype wire

// File: sim/tb_mono_lcd_framebuffer_controller_top.sv
`timescale 1ns / 1ps
module tb_mono_lcd_framebuffer_controller_top;
   import mlfc_pkg::*;

   localparam int FRAME_BYTES   = FRAME_BYTES_DEF;
   localparam int CYCLE_LIMIT   = 2000000;
   localparam int ITEM_TARGET   = 1350;
   localparam int SETTLE_CYCLES = 64;
   localparam int MAX_PRINTED   = 40;

   // action code the block has no use for
   localparam logic [1:0] ACT_UNUSED = 2'd3;

   logic                  clock;
   logic                  reset;
   logic                  start;
   logic                  busy;
   req_item_type          req_item;
   logic                  rsp_valid;
   rsp_item_type          rsp_item;
   logic                  csr_wr_en;
   logic                  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   mono_lcd_framebuffer_controller_top #(
      .FRAME_BYTES(FRAME_BYTES)
   ) uut (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_item (req_item),
      .rsp_valid(rsp_valid),
      .rsp_item (rsp_item),
      .csr_wr_en(csr_wr_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   // shadow copy of the display state
   logic [7:0]   shadow_frame [FRAME_BYTES];
   logic         shadow_pending;
   phase_type    shadow_phase;
   int unsigned  shadow_pos;
   logic [2:0]   shadow_mode;
   logic [10:0]  shadow_size;
   rsp_item_type expected_lcd_bytes[$];

   int unsigned cycle_count;
   int unsigned error_count;
   int unsigned items_sent;
   int unsigned bytes_checked;
   int unsigned frames_streamed;
   int unsigned register_writes;
   logic        no_gaps;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("run stopped at cycle limit %0d", cycle_count);
         $display("tb_mono_lcd_framebuffer_controller_top: errors");
         $finish;
      end
   end

   task automatic report_mismatch(input string what, input int unsigned want,
                                  input int unsigned got);
      error_count++;
      if (error_count <= MAX_PRINTED)
         $display("mismatch at cycle %0d: %s expected %0h got %0h", cycle_count, what, want,
                  got);
   endtask

   // compare every lcd byte with the oldest prediction
   always @(posedge clock) begin
      rsp_item_type want;
      if (!reset && rsp_valid !== 1'b0) begin
         if (expected_lcd_bytes.size() == 0) begin
            report_mismatch("lcd byte with none predicted", 0, rsp_item.out_byte);
         end else begin
            want = expected_lcd_bytes.pop_front();
            bytes_checked++;
            if (rsp_valid !== 1'b1)
               report_mismatch("rsp_valid", 1, rsp_valid);
            if (rsp_item.is_command !== want.is_command)
               report_mismatch("is_command", want.is_command, rsp_item.is_command);
            if (rsp_item.out_byte !== want.out_byte)
               report_mismatch("out_byte", want.out_byte, rsp_item.out_byte);
            if (rsp_item.frame_done !== want.frame_done)
               report_mismatch("frame_done", want.frame_done, rsp_item.frame_done);
         end
      end
   end

   function automatic int unsigned bytes_used();
      return (shadow_size > FRAME_BYTES) ? FRAME_BYTES : shadow_size;
   endfunction

   function automatic logic [7:0] blend_pixels(input logic [7:0] w, input logic [7:0] d,
                                               input logic [7:0] m);
      case (shadow_mode)
         MODE_OR:       return w | d;
         MODE_ANDNOT:   return w & ~d;
         MODE_OVER:     return (w & ~m) | d;
         MODE_OVER_INV: return (w & ~m) | (d ^ m);
         MODE_XOR:      return w ^ d;
         default:       return w;
      endcase
   endfunction

   function automatic rsp_item_type lcd_byte(input logic cmd, input logic [7:0] b,
                                             input logic done);
      rsp_item_type r;
      r.is_command = cmd;
      r.out_byte   = b;
      r.frame_done = done;
      return r;
   endfunction

   function automatic req_item_type lcd_request(input logic [1:0] action,
                                                input logic [9:0] index,
                                                input logic [7:0] pixel,
                                                input logic [7:0] mask);
      req_item_type it;
      it.action     = action;
      it.index      = index;
      it.pixel_byte = pixel;
      it.mask       = mask;
      return it;
   endfunction

   // advance the shadow state by one accepted item
   function automatic void display_step(input req_item_type it);
      int unsigned used;
      int unsigned limit;
      int unsigned pos;
      int unsigned i;
      logic        done;
      used = bytes_used();
      case (it.action)
         ACT_WRITE: begin
            if (it.index < used) begin
               shadow_frame[it.index] = blend_pixels(shadow_frame[it.index], it.pixel_byte,
                                                     it.mask);
               shadow_pending = 1'b1;
            end
         end
         ACT_CLEAR: begin
            for (i = 0; i < used; i++)
               shadow_frame[i] = 8'h00;
            expected_lcd_bytes.push_back(lcd_byte(1'b1, CMD_DISP_NORM, 1'b0));
         end
         ACT_TICK: begin
            if (shadow_phase == PH_SET_Y) begin
               expected_lcd_bytes.push_back(lcd_byte(1'b1, CMD_SET_Y, 1'b0));
               shadow_phase = PH_DATA;
               shadow_pos   = 0;
            end else if (shadow_phase == PH_DATA) begin
               // an empty buffer still streams the byte at position zero
               limit = (used == 0) ? 1 : used;
               pos   = (shadow_pos >= FRAME_BYTES) ? FRAME_BYTES - 1 : shadow_pos;
               done  = (pos + 1 >= limit);
               if (done) begin
                  shadow_phase = PH_IDLE;
                  shadow_pos   = 0;
                  frames_streamed++;
               end else begin
                  shadow_pos = pos + 1;
               end
               expected_lcd_bytes.push_back(lcd_byte(1'b0, shadow_frame[pos], done));
            end else begin
               shadow_phase = PH_IDLE;
               if (shadow_pending) begin
                  shadow_pending = 1'b0;
                  shadow_phase   = PH_SET_Y;
                  expected_lcd_bytes.push_back(lcd_byte(1'b1, CMD_SET_X, 1'b0));
               end
            end
         end
         default: ;
      endcase
   endfunction

   function automatic int unsigned pick_gap();
      int unsigned r;
      if (no_gaps)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic int unsigned pick_index(input int unsigned used);
      if (used == 0 || $urandom_range(0, 9) == 0)
         return $urandom_range(0, FRAME_BYTES - 1);
      return $urandom_range(0, used - 1);
   endfunction

   // start stays high after the item when gap is zero: the caller sends again at once
   task automatic send_item(input req_item_type it, input int unsigned gap);
      @(negedge clock);
      start    <= 1'b1;
      req_item <= it;
      @(posedge clock);
      while (busy)
         @(posedge clock);
      display_step(it);
      items_sent++;
      if (gap > 0) begin
         @(negedge clock);
         start <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   task automatic drain_results();
      @(negedge clock);
      start <= 1'b0;
      while (expected_lcd_bytes.size() != 0)
         @(negedge clock);
   endtask

   task automatic write_register(input logic idx, input logic [CSR_DATA_W-1:0] value);
      drain_results();
      // a write item leaves no lcd byte but may still be in flight
      repeat (4) @(negedge clock);
      while (busy)
         @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      if (idx == CSR_DRAW_MODE)
         shadow_mode = value[2:0];
      else
         shadow_size = value[10:0];
      register_writes++;
   endtask

   task automatic send_ticks(input int unsigned n);
      int unsigned i;
      for (i = 0; i < n; i++)
         send_item(lcd_request(ACT_TICK, 10'($urandom), 8'($urandom), 8'($urandom)),
                   pick_gap());
   endtask

   task automatic test_idle_actions();
      send_item(lcd_request(ACT_TICK, 10'h000, 8'h00, 8'h00), pick_gap());
      send_item(lcd_request(ACT_UNUSED, 10'h3FF, 8'hFF, 8'hFF), pick_gap());
   endtask

   task automatic test_draw_modes();
      int unsigned m;
      // reset mode is overwrite, reset size 504
      send_item(lcd_request(ACT_WRITE, 10'd0, 8'hFF, 8'hFF), pick_gap());
      send_item(lcd_request(ACT_WRITE, 10'd503, 8'h00, 8'h00), pick_gap());
      send_item(lcd_request(ACT_WRITE, 10'd504, 8'hFF, 8'hFF), pick_gap());
      send_item(lcd_request(ACT_WRITE, 10'h3FF, 8'hFF, 8'h00), pick_gap());
      write_register(CSR_BUFFER_SIZE, 11'd2);
      for (m = 0; m < 8; m++) begin
         write_register(CSR_DRAW_MODE, {8'hFF, 3'(m)});
         send_item(lcd_request(ACT_WRITE, 10'd1, 8'hA5 ^ 8'(m * 8'h13), 8'h3C), pick_gap());
      end
   endtask

   task automatic test_refresh();
      // set-x, set-y, two bytes, then nothing pending
      send_ticks(5);
   endtask

   task automatic test_clear();
      send_item(lcd_request(ACT_CLEAR, 10'd0, 8'h00, 8'h00), pick_gap());
      write_register(CSR_DRAW_MODE, {8'h00, MODE_XOR});
      write_register(CSR_BUFFER_SIZE, 11'h7FF);
      send_item(lcd_request(ACT_WRITE, 10'h3FF, 8'h81, 8'h00), pick_gap());
      send_item(lcd_request(ACT_CLEAR, 10'h3FF, 8'hFF, 8'hFF), pick_gap());
   endtask

   task automatic test_buffer_limits();
      // empty buffer: writes ignored, refresh still sends byte zero
      write_register(CSR_DRAW_MODE, {8'h00, MODE_OVER});
      write_register(CSR_BUFFER_SIZE, 11'd1);
      send_item(lcd_request(ACT_WRITE, 10'd0, 8'h5A, 8'hFF), pick_gap());
      write_register(CSR_BUFFER_SIZE, 11'd0);
      send_item(lcd_request(ACT_WRITE, 10'd0, 8'hFF, 8'hFF), pick_gap());
      send_ticks(3);
      send_item(lcd_request(ACT_CLEAR, 10'd0, 8'h00, 8'h00), pick_gap());
      // buffer shrinks below the position while streaming
      write_register(CSR_BUFFER_SIZE, 11'd6);
      send_item(lcd_request(ACT_WRITE, 10'd5, 8'hC3, 8'h0F), pick_gap());
      send_ticks(5);
      write_register(CSR_BUFFER_SIZE, 11'd1);
      send_ticks(1);
   endtask

   task automatic run_frame_sequence(input int unsigned n_writes);
      int unsigned i;
      int unsigned used;
      used = bytes_used();
      for (i = 0; i < n_writes; i++)
         send_item(lcd_request(ACT_WRITE, 10'(pick_index(used)), 8'($urandom),
                               8'($urandom)), pick_gap());
      send_ticks(((used == 0) ? 1 : used) + 3);
   endtask

   task automatic test_random_traffic();
      int unsigned phase_no;
      int unsigned units;
      int unsigned u;
      int unsigned i;
      int unsigned r;
      int unsigned stop_at;
      logic [10:0] size;
      phase_no = 0;
      stop_at  = ITEM_TARGET;
      while (items_sent < stop_at) begin
         no_gaps = ($urandom_range(0, 3) == 0);
         if (phase_no == 0 || $urandom_range(0, 9) < 7)
            write_register(CSR_DRAW_MODE, {8'($urandom), 3'($urandom_range(0, 7))});
         r = $urandom_range(0, 99);
         if (phase_no == 2) begin
            r    = $urandom_range(0, 2);
            size = (r == 0) ? 11'd504 : ((r == 1) ? 11'd1024 : 11'h7FF);
         end else if (r < 10) begin
            size = 11'd0;
         end else if (r < 75) begin
            size = 11'($urandom_range(1, 16));
         end else begin
            size = 11'($urandom_range(17, 64));
         end
         if (phase_no == 0 || phase_no == 2 || $urandom_range(0, 9) < 7)
            write_register(CSR_BUFFER_SIZE, size);
         if (phase_no == 2) begin
            run_frame_sequence(20);
         end else begin
            units = $urandom_range(4, 10);
            for (u = 0; u < units; u++) begin
               r = $urandom_range(0, 99);
               if (r < 65) begin
                  run_frame_sequence($urandom_range(1, 6));
               end else if (r < 95) begin
                  for (i = $urandom_range(1, 4); i > 0; i--)
                     send_item(lcd_request(2'($urandom_range(0, 3)), 10'($urandom),
                                           8'($urandom), 8'($urandom)), pick_gap());
               end else begin
                  drain_results();
               end
            end
         end
         phase_no++;
      end
   endtask

   initial begin
      int unsigned i;
      reset     = 1'b1;
      start     = 1'b0;
      req_item  = '0;
      csr_wr_en = 1'b0;
      csr_index = 1'b0;
      csr_wdata = '0;
      no_gaps   = 1'b0;
      for (i = 0; i < FRAME_BYTES; i++)
         shadow_frame[i] = 8'h00;
      shadow_pending = 1'b0;
      shadow_phase   = PH_IDLE;
      shadow_pos     = 0;
      shadow_mode    = DRAW_MODE_RST;
      shadow_size    = BUFFER_SIZE_RST;
      repeat (11) @(negedge clock);
      reset <= 1'b0;

      test_idle_actions();
      test_draw_modes();
      test_refresh();
      test_clear();
      test_buffer_limits();
      test_random_traffic();

      drain_results();
      repeat (SETTLE_CYCLES) @(negedge clock);
      $display("sent %0d items, checked %0d lcd bytes, %0d full frames streamed",
               items_sent, bytes_checked, frames_streamed);
      $display("%0d register writes across draw modes and buffer sizes, %0d mismatches",
               register_writes, error_count);
      if (error_count == 0) begin
         $display("tb_mono_lcd_framebuffer_controller_top: clean");
      end else begin
         $display("tb_mono_lcd_framebuffer_controller_top: errors");
      end
      $finish;
   end

endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/mlfc_pkg.sv
rtl/core/mlfc_ram.sv
rtl/core/mono_lcd_framebuffer_controller_top.sv
rtl/core/mlfc_checker.sv
sim/tb_mono_lcd_framebuffer_controller_top.sv
